// ===== hw/rtl/sidtc_pkg.sv =====
// sidtc_pkg: shared types, constants and state codes for the signed integer
// to decimal text cell block
// no dependencies
package sidtc_pkg;

   localparam int BIN_W       = 32;
   localparam int NUM_DIGITS  = 10;
   localparam int BCD_W       = 4 * NUM_DIGITS;
   localparam int CNT_W       = $clog2(BIN_W);
   localparam int DIG_W       = $clog2(NUM_DIGITS);
   localparam int IDX_W       = 11;
   localparam int DEF_SCREEN_WIDTH = 80;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic signed [31:0] number;
      logic [4:0]         row;
      logic [6:0]         col;
      logic [7:0]         color;
   } req_type;

   typedef struct packed {
      logic [10:0] cell_index;
      logic [15:0] cell_word;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_DIGIT
   } state_type;

endpackage

// ===== hw/rtl/sidtc_dabble.sv =====
// sidtc_dabble: one shift-and-add-3 step of the binary to bcd converter
// depends on sidtc_pkg
module sidtc_dabble (
   input  logic [sidtc_pkg::BCD_W-1:0] bcd_cur,
   input  logic [sidtc_pkg::BIN_W-1:0] bin_cur,
   output logic [sidtc_pkg::BCD_W-1:0] bcd_nxt,
   output logic [sidtc_pkg::BIN_W-1:0] bin_nxt
);
   import sidtc_pkg::*;

   logic [BCD_W-1:0] bcd_adj;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_cur[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_cur[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_cur[i*4 +: 4];
         end
      end
   end

   assign bcd_nxt = {bcd_adj[BCD_W-2:0], bin_cur[BIN_W-1]};
   assign bin_nxt = {bin_cur[BIN_W-2:0], 1'b0};

endmodule

// ===== hw/rtl/signed_int_to_decimal_text_cells_core.sv =====
// signed_int_to_decimal_text_cells_core: top level, sequencer and cell output
// depends on sidtc_pkg and sidtc_dabble
//
// Usage:
//   A request word (number, row, col, color) is taken at a rising edge with
//   start high and busy low. busy stays high until the last cell of that
//   number has been sent.
//   The number's magnitude goes through a shared shift-and-add-3 step, one
//   bit per cycle, over every bit. Leading zero digits are then skipped one
//   per cycle, and the characters leave one per cycle, minus sign first.
//   Each cell is on rsp_word for exactly one cycle with rsp_strobe high;
//   rsp_word.last marks the final cell. The receiver cannot stall.
//   Busy time per number covers the conversion steps, the skip of leading
//   zero digits, the minus sign of a negative number and one cell per
//   decimal digit. A new start is taken at the first rising edge with busy
//   low.
//   cell_index = row*SCREEN_WIDTH + col + position, modulo 2048.
//   Synchronous reset returns the block to idle; a number in flight is
//   dropped and no further cells appear.
module signed_int_to_decimal_text_cells_core #(
   parameter int SCREEN_WIDTH = sidtc_pkg::DEF_SCREEN_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sidtc_pkg::req_type req_word,
   output logic               rsp_strobe,
   output sidtc_pkg::rsp_type rsp_word
);
   import sidtc_pkg::*;

   localparam int SW_W = $clog2(SCREEN_WIDTH + 1);
   localparam int PROD_W = 5 + SW_W;

   state_type state_ff, state_in;

   logic [BIN_W-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic             neg_ff, neg_in;
   logic [7:0]       color_ff, color_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic [BCD_W-1:0] bcd_step;
   logic [BIN_W-1:0] mag_step;
   logic [BIN_W-1:0] mag_load;
   logic [PROD_W-1:0] row_prod;
   logic [IDX_W-1:0] base_idx;
   logic [3:0]       cur_digit;
   logic             accept;

   sidtc_dabble u_dabble (
      .bcd_cur (bcd_ff),
      .bin_cur (mag_ff),
      .bcd_nxt (bcd_step),
      .bin_nxt (mag_step)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign mag_load  = req_word.number[31] ? (32'd0 - 32'(req_word.number))
                                          : 32'(req_word.number);
   assign row_prod  = PROD_W'(req_word.row) * PROD_W'(SCREEN_WIDTH);
   assign base_idx  = IDX_W'(row_prod) + IDX_W'(req_word.col);
   assign cur_digit = bcd_ff[{dig_ff, 2'b00} +: 4];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (cnt_ff == CNT_W'(BIN_W - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (cur_digit != 4'd0 || dig_ff == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (dig_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath updates
   always_comb begin
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      dig_in   = dig_ff;
      neg_in   = neg_ff;
      color_in = color_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mag_in   = mag_load;
               bcd_in   = '0;
               cnt_in   = '0;
               neg_in   = req_word.number[31];
               color_in = req_word.color;
               idx_in   = base_idx;
            end
         end
         ST_CONV: begin
            mag_in = mag_step;
            bcd_in = bcd_step;
            cnt_in = cnt_ff + 1'b1;
            dig_in = DIG_W'(NUM_DIGITS - 1);
         end
         ST_SKIP: begin
            if (cur_digit == 4'd0 && dig_ff != '0) begin
               dig_in = dig_ff - 1'b1;
            end
         end
         ST_SIGN: begin
            idx_in = idx_ff + 1'b1;
         end
         ST_DIGIT: begin
            idx_in = idx_ff + 1'b1;
            if (dig_ff != '0) begin
               dig_in = dig_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      busy                = (state_ff != ST_IDLE);
      rsp_strobe          = 1'b0;
      rsp_word.cell_index = idx_ff;
      rsp_word.cell_word  = {color_ff, CHAR_ZERO + {4'd0, cur_digit}};
      rsp_word.last       = 1'b0;
      case (state_ff)
         ST_SIGN: begin
            rsp_strobe         = 1'b1;
            rsp_word.cell_word = {color_ff, CHAR_MINUS};
         end
         ST_DIGIT: begin
            rsp_strobe    = 1'b1;
            rsp_word.last = (dig_ff == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      bcd_ff   <= bcd_in;
      cnt_ff   <= cnt_in;
      dig_ff   <= dig_in;
      neg_ff   <= neg_in;
      color_ff <= color_in;
      idx_ff   <= idx_in;
   end

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("cell strobe while idle");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.last) |=> !busy)
      else $error("still busy after last cell");

   a_conv_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && cnt_ff == CNT_W'(BIN_W - 1)) |=> state_ff == ST_SKIP)
      else $error("conversion did not end after all bits");

   a_accept_conv: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_CONV && cnt_ff == '0))
      else $error("accepted word did not start conversion");

endmodule

// ===== bench/signed_int_to_decimal_text_cells_core_tb.sv =====
`timescale 1ns / 1ps
// signed_int_to_decimal_text_cells_core_tb: self-checking bench for the decimal text cell block,
// predicts every cell write of each accepted number and compares word by word
// depends on sidtc_pkg and signed_int_to_decimal_text_cells_core
module signed_int_to_decimal_text_cells_core_tb;
   import sidtc_pkg::*;

   localparam int SCREEN_WIDTH = DEF_SCREEN_WIDTH;
   localparam int RANDOM_NUMBERS = 250;
   localparam int QUIET_TAIL = 40;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      req_type word;
      bit      drain;
   } number_request_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   number_request_type pending_numbers[$];
   rsp_type            expected_cells[$];
   rsp_type            want;
   int                 mismatch_count = 0;
   int                 gap_left = 0;

   signed_int_to_decimal_text_cells_core #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_word(req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word(rsp_word)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   function automatic void queue_number_cells(input req_type w);
      logic [31:0] mag;
      logic [7:0]  text[11];
      int          digits[10];
      int          n;
      int          len;
      int unsigned base;
      rsp_type     out_cell;
      mag = w.number[31] ? (32'd0 - w.number) : w.number;
      base = w.row * SCREEN_WIDTH + w.col;
      len = 0;
      if (mag == 0) begin
         text[0] = CHAR_ZERO;
         len = 1;
      end else begin
         n = 0;
         while (mag != 0) begin
            digits[n] = mag % 10;
            mag = mag / 10;
            n++;
         end
         if (w.number[31]) begin
            text[len] = CHAR_MINUS;
            len++;
         end
         for (int k = n - 1; k >= 0; k--) begin
            text[len] = CHAR_ZERO + 8'(digits[k]);
            len++;
         end
      end
      for (int k = 0; k < len; k++) begin
         out_cell.cell_index = 11'(base + k);
         out_cell.cell_word = {w.color, text[k]};
         out_cell.last = (k == len - 1);
         expected_cells.push_back(out_cell);
      end
   endfunction

   function automatic logic signed [31:0] random_number();
      longint lo;
      longint hi;
      longint mag;
      int     digits;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? -$urandom_range(0, 9) : $urandom_range(0, 9);
         default: begin
            digits = $urandom_range(1, 10);
            lo = 1;
            for (int k = 1; k < digits; k++) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'sd2147483647) hi = 64'sd2147483647;
            mag = lo + (longint'($urandom) % (hi - lo + 1));
            return $urandom_range(0, 1) ? 32'(-mag) : 32'(mag);
         end
      endcase
   endfunction

   function automatic void add_number(input logic signed [31:0] number, input int row,
                                      input int col, input int color, input bit drain);
      number_request_type item;
      item.word.number = number;
      item.word.row = 5'(row);
      item.word.col = 7'(col);
      item.word.color = 8'(color);
      item.drain = drain;
      pending_numbers.push_back(item);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (start && !busy && !reset) queue_number_cells(req_word);
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else if (pending_numbers.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
         gap_left = $urandom_range(1, 19) - 1;
         start <= 1'b0;
      end else if (pending_numbers.size() == 0) begin
         start <= 1'b0;
      end else if (pending_numbers[0].drain && (expected_cells.size() != 0 || busy)) begin
         start <= 1'b0;
      end else begin
         req_word <= pending_numbers[0].word;
         start <= 1'b1;
         void'(pending_numbers.pop_front());
      end
   end

   // cell monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_cells.size() == 0) begin
            report_mismatch($sformatf("unexpected cell index %0d word %h last %b",
                                      rsp_word.cell_index, rsp_word.cell_word, rsp_word.last));
         end else begin
            want = expected_cells.pop_front();
            if (rsp_word.cell_index !== want.cell_index)
               report_mismatch($sformatf("cell_index %0d, expected %0d",
                                         rsp_word.cell_index, want.cell_index));
            if (rsp_word.cell_word !== want.cell_word)
               report_mismatch($sformatf("cell_word %h, expected %h",
                                         rsp_word.cell_word, want.cell_word));
            if (rsp_word.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b at index %0d",
                                         rsp_word.last, want.last, want.cell_index));
         end
      end
   end

   initial begin
      add_number(0, 0, 0, 8'h07, 1'b0);
      add_number(1, 24, 79, 8'hFF, 1'b0);
      add_number(-1, 0, 79, 8'h00, 1'b0);
      add_number(9, 12, 40, 8'hA5, 1'b0);
      add_number(10, 1, 1, 8'h5A, 1'b0);
      add_number(-10, 24, 0, 8'h1F, 1'b0);
      add_number(32'sh7FFFFFFF, 24, 79, 8'hFF, 1'b0);
      add_number(32'sh80000000, 24, 75, 8'h80, 1'b0);
      add_number(32'sh80000000, 0, 0, 8'h01, 1'b0);
      add_number(1000000000, 5, 70, 8'h3C, 1'b0);
      add_number(-999999999, 10, 33, 8'hC3, 1'b0);
      add_number(123456789, 31, 127, 8'h0F, 1'b0);
      add_number(-2147483647, 31, 120, 8'hF0, 1'b0);
      add_number(0, 31, 127, 8'hFF, 1'b0);
      add_number(-5, 25, 80, 8'h42, 1'b0);
      add_number(99999, 24, 127, 8'h24, 1'b0);
      for (int k = 0; k < RANDOM_NUMBERS; k++) begin
         add_number(random_number(),
                    $urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 24),
                    $urandom_range(0, 7) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 79),
                    $urandom_range(0, 255), k == 80 || k == 170);
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (pending_numbers.size() != 0 || start) @(posedge clock);
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_cells.size() != 0)
         report_mismatch($sformatf("%0d cells never arrived", expected_cells.size()));
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

endmodule

// ===== signed_int_to_decimal_text_cells_core.f =====
hw/rtl/sidtc_pkg.sv
hw/rtl/sidtc_dabble.sv
hw/rtl/signed_int_to_decimal_text_cells_core.sv
bench/signed_int_to_decimal_text_cells_core_tb.sv
